/* sv/ace_pkg.sv */
// shared types and constants of the arm code emitter
// opcode templates, command codes, micro-op word, state enums
// no dependencies
`default_nettype none

package ace_pkg;

    localparam int LABEL_SLOTS = 32;
    localparam int SLOT_W      = $clog2(LABEL_SLOTS);
    localparam int CNT_W       = SLOT_W + 1;
    localparam int CODE_WORDS  = 4096;
    localparam int ADDR_W      = $clog2(CODE_WORDS);
    localparam int QUEUE_DEPTH = 4;
    localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_W     = Q_PTR_W + 1;

    localparam logic [ADDR_W-1:0] POOL_START_RESET = ADDR_W'(128);

    // configuration register indexes
    localparam logic CFG_POOL_START = 1'b0;
    localparam logic CFG_DIV_ADDR   = 1'b1;

    // command codes
    localparam logic [4:0] CMD_INIT  = 5'd0;
    localparam logic [4:0] CMD_MOVI  = 5'd1;
    localparam logic [4:0] CMD_MOVR  = 5'd2;
    localparam logic [4:0] CMD_MOVMI = 5'd3;
    localparam logic [4:0] CMD_MOVNE = 5'd4;
    localparam logic [4:0] CMD_LDR   = 5'd5;
    localparam logic [4:0] CMD_LDRB  = 5'd6;
    localparam logic [4:0] CMD_STRB  = 5'd7;
    localparam logic [4:0] CMD_STRW  = 5'd8;
    localparam logic [4:0] CMD_ADDR  = 5'd9;
    localparam logic [4:0] CMD_ADDI  = 5'd10;
    localparam logic [4:0] CMD_SUBR  = 5'd11;
    localparam logic [4:0] CMD_MULR  = 5'd12;
    localparam logic [4:0] CMD_CALL  = 5'd13;
    localparam logic [4:0] CMD_DIVR  = 5'd14;
    localparam logic [4:0] CMD_CMPR  = 5'd15;
    localparam logic [4:0] CMD_CMPI  = 5'd16;
    localparam logic [4:0] CMD_BEQ   = 5'd17;
    localparam logic [4:0] CMD_BNE   = 5'd18;
    localparam logic [4:0] CMD_BMI   = 5'd19;
    localparam logic [4:0] CMD_B     = 5'd20;
    localparam logic [4:0] CMD_LABEL = 5'd21;
    localparam logic [4:0] CMD_RET   = 5'd22;

    // instruction templates
    localparam logic [31:0] OP_LDR    = 32'he5900000;
    localparam logic [31:0] OP_STR    = 32'he5800000;
    localparam logic [31:0] OP_MOV    = 32'he1a00000;
    localparam logic [31:0] OP_MOVMI  = 32'h41a00000;
    localparam logic [31:0] OP_MOVNE  = 32'h11a00000;
    localparam logic [31:0] OP_ADDS   = 32'he0900000;
    localparam logic [31:0] OP_SUBS   = 32'he0500000;
    localparam logic [31:0] OP_MULS   = 32'he0100090;
    localparam logic [31:0] OP_CMP    = 32'he1500000;
    localparam logic [31:0] OP_CMPI   = 32'he3500000;
    localparam logic [31:0] OP_PUSH   = 32'he92d4000;
    localparam logic [31:0] OP_POP    = 32'he8bd4000;
    localparam logic [31:0] BYTE_BIT  = 32'h00400000;

    // branch top bytes
    localparam logic [7:0] BR_EQ = 8'h0a;
    localparam logic [7:0] BR_NE = 8'h1a;
    localparam logic [7:0] BR_MI = 8'h4a;
    localparam logic [7:0] BR_AL = 8'hea;

    typedef enum logic [2:0] {
        UOP_EMIT,
        UOP_MOVI,
        UOP_BRANCH,
        UOP_LABEL,
        UOP_INIT
    } uop_kind_t;

    // one step of work for the back end; branch top byte sits in word[7:0]
    typedef struct packed {
        uop_kind_t   kind;
        logic [31:0] word;
        logic [3:0]  rn;
        logic [7:0]  id;
        logic        fin;
    } uop_t;

    typedef enum logic {
        F_IDLE,
        F_EXPAND
    } front_state_t;

    typedef enum logic [2:0] {
        B_FETCH,
        B_EXEC,
        B_MOVI2,
        B_BSCAN,
        B_BEMIT,
        B_LSCAN,
        B_FLUSH
    } back_state_t;

    // register-register form: base | s | d << 12
    function automatic logic [31:0] rr_word(input logic [31:0] base, input logic [3:0] d,
                                            input logic [3:0] s);
        rr_word = base | {16'b0, d, 8'b0, s};
    endfunction

endpackage

`default_nettype wire

/* sv/ace_front.sv */
// front end: accepts emit commands and expands them into micro-ops
// uses ace_pkg
`default_nettype none

module ace_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [55:0]       s_tdata,
    input  logic [31:0]       div_addr,
    input  logic              q_full,
    output logic              push,
    output ace_pkg::uop_t     push_uop
);

    ace_pkg::front_state_t state_reg, state_next;
    logic [4:0]  cmd_reg;
    logic [3:0]  d_reg;
    logic [3:0]  s_reg;
    logic [31:0] imm_reg;
    logic [7:0]  id_reg;
    logic [2:0]  step_reg, step_next;

    logic          have_uop;
    logic          last_step;
    logic [2:0]    div_step;
    ace_pkg::uop_t u;

    function automatic ace_pkg::uop_t call_uop(input logic [1:0] st, input logic [31:0] target);
        ace_pkg::uop_t c;
        c      = '0;
        c.kind = ace_pkg::UOP_EMIT;
        case (st)
            2'd0: begin
                c.word = ace_pkg::OP_PUSH;
            end
            2'd1: begin
                c.word = ace_pkg::rr_word(ace_pkg::OP_MOV, 4'd14, 4'd15);
            end
            2'd2: begin
                c.kind = ace_pkg::UOP_MOVI;
                c.word = target;
                c.rn   = 4'd15;
            end
            default: begin
                c.word = ace_pkg::OP_POP;
            end
        endcase
        call_uop = c;
    endfunction

    assign div_step = step_reg - 3'd2;

    // command expansion table
    always_comb begin
        u         = '0;
        u.kind    = ace_pkg::UOP_EMIT;
        have_uop  = 1'b1;
        last_step = 1'b1;
        case (cmd_reg)
            ace_pkg::CMD_INIT:  u.kind = ace_pkg::UOP_INIT;
            ace_pkg::CMD_MOVI: begin
                u.kind = ace_pkg::UOP_MOVI;
                u.word = imm_reg;
                u.rn   = d_reg;
            end
            ace_pkg::CMD_MOVR:  u.word = ace_pkg::rr_word(ace_pkg::OP_MOV, d_reg, s_reg);
            ace_pkg::CMD_MOVMI: u.word = ace_pkg::rr_word(ace_pkg::OP_MOVMI, d_reg, s_reg);
            ace_pkg::CMD_MOVNE: u.word = ace_pkg::rr_word(ace_pkg::OP_MOVNE, d_reg, s_reg);
            ace_pkg::CMD_LDR:
                u.word = ace_pkg::OP_LDR | {12'b0, d_reg, d_reg, 12'b0};
            ace_pkg::CMD_LDRB:
                u.word = ace_pkg::OP_LDR | ace_pkg::BYTE_BIT | {12'b0, 4'd3, d_reg, 12'b0};
            ace_pkg::CMD_STRB:
                u.word = ace_pkg::OP_STR | ace_pkg::BYTE_BIT | {12'b0, 4'd3, d_reg, 12'b0};
            ace_pkg::CMD_STRW:
                u.word = ace_pkg::OP_STR | {12'b0, d_reg, 4'd3, 12'b0};
            ace_pkg::CMD_ADDR:
                u.word = ace_pkg::OP_ADDS | {12'b0, d_reg, d_reg, 8'b0, s_reg};
            ace_pkg::CMD_ADDI: begin
                if (step_reg == 3'd0) begin
                    u.kind    = ace_pkg::UOP_MOVI;
                    u.word    = imm_reg;
                    u.rn      = 4'd9;
                    last_step = 1'b0;
                end else begin
                    u.word = ace_pkg::OP_ADDS | {12'b0, d_reg, d_reg, 8'b0, 4'd9};
                end
            end
            ace_pkg::CMD_SUBR:
                u.word = ace_pkg::OP_SUBS | {12'b0, d_reg, d_reg, 8'b0, s_reg};
            ace_pkg::CMD_MULR:
                u.word = ace_pkg::OP_MULS | {12'b0, d_reg, 4'b0, s_reg, 4'b0, d_reg};
            ace_pkg::CMD_CALL: begin
                u         = call_uop(step_reg[1:0], imm_reg);
                last_step = (step_reg == 3'd3);
            end
            ace_pkg::CMD_DIVR: begin
                case (step_reg)
                    3'd0: u.word = ace_pkg::rr_word(ace_pkg::OP_MOV, 4'd0, d_reg);
                    3'd1: u.word = ace_pkg::rr_word(ace_pkg::OP_MOV, 4'd1, s_reg);
                    3'd6: u.word = ace_pkg::rr_word(ace_pkg::OP_MOV, d_reg, 4'd0);
                    default: u = call_uop(div_step[1:0], div_addr);
                endcase
                // the move back into d is skipped when d is r0
                last_step = (step_reg == 3'd6) || (step_reg == 3'd5 && d_reg == 4'd0);
            end
            ace_pkg::CMD_CMPR:
                u.word = ace_pkg::OP_CMP | {12'b0, d_reg, 12'b0, s_reg};
            ace_pkg::CMD_CMPI:
                u.word = ace_pkg::OP_CMPI | {12'b0, s_reg, imm_reg[15:0]};
            ace_pkg::CMD_BEQ: begin
                u.kind = ace_pkg::UOP_BRANCH;
                u.word = {24'b0, ace_pkg::BR_EQ};
                u.id   = id_reg;
            end
            ace_pkg::CMD_BNE: begin
                u.kind = ace_pkg::UOP_BRANCH;
                u.word = {24'b0, ace_pkg::BR_NE};
                u.id   = id_reg;
            end
            ace_pkg::CMD_BMI: begin
                u.kind = ace_pkg::UOP_BRANCH;
                u.word = {24'b0, ace_pkg::BR_MI};
                u.id   = id_reg;
            end
            ace_pkg::CMD_B: begin
                u.kind = ace_pkg::UOP_BRANCH;
                u.word = {24'b0, ace_pkg::BR_AL};
                u.id   = id_reg;
            end
            ace_pkg::CMD_LABEL: begin
                u.kind = ace_pkg::UOP_LABEL;
                u.id   = id_reg;
            end
            ace_pkg::CMD_RET: u.word = ace_pkg::rr_word(ace_pkg::OP_MOV, 4'd15, 4'd14);
            default: have_uop = 1'b0;
        endcase
        u.fin = last_step;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            ace_pkg::F_IDLE: begin
                if (s_tvalid) begin
                    state_next = ace_pkg::F_EXPAND;
                    step_next  = 3'd0;
                end
            end
            ace_pkg::F_EXPAND: begin
                if (!have_uop) begin
                    state_next = ace_pkg::F_IDLE;
                end else if (!q_full) begin
                    if (last_step) begin
                        state_next = ace_pkg::F_IDLE;
                    end else begin
                        step_next = step_reg + 3'd1;
                    end
                end
            end
            default: state_next = ace_pkg::F_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_tready = (state_reg == ace_pkg::F_IDLE);
        push     = (state_reg == ace_pkg::F_EXPAND) && have_uop && !q_full;
        push_uop = u;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ace_pkg::F_IDLE;
            step_reg  <= 3'd0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            cmd_reg <= s_tdata[4:0];
            d_reg   <= s_tdata[8:5];
            s_reg   <= s_tdata[12:9];
            imm_reg <= s_tdata[44:13];
            id_reg  <= s_tdata[52:45];
        end
    end

endmodule

`default_nettype wire

/* sv/ace_queue.sv */
// short micro-op queue between front and back end
// uses ace_pkg
`default_nettype none

module ace_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  ace_pkg::uop_t push_uop,
    output logic          full,
    input  logic          pop,
    output logic          valid,
    output ace_pkg::uop_t head_uop
);

    ace_pkg::uop_t                 mem_reg [ace_pkg::QUEUE_DEPTH];
    logic [ace_pkg::Q_PTR_W-1:0]   head_reg, head_next;
    logic [ace_pkg::Q_PTR_W-1:0]   tail_reg, tail_next;
    logic [ace_pkg::Q_CNT_W-1:0]   count_reg, count_next;

    always_comb begin
        full       = (count_reg == ace_pkg::Q_CNT_W'(ace_pkg::QUEUE_DEPTH));
        valid      = (count_reg != '0);
        head_uop   = mem_reg[head_reg];
        head_next  = pop ? head_reg + 1'b1 : head_reg;
        tail_next  = push ? tail_reg + 1'b1 : tail_reg;
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[tail_reg] <= push_uop;
        end
    end

endmodule

`default_nettype wire

/* sv/ace_back.sv */
// back end: runs micro-ops, keeps code/pool indexes and label tables
// uses ace_pkg; drives the result channel through a hold and output register
`default_nettype none

module ace_back (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [ace_pkg::ADDR_W-1:0] pool_start,
    input  logic                       q_valid,
    input  ace_pkg::uop_t              q_uop,
    output logic                       q_pop,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [47:0]                m_tdata,
    output logic                       m_tlast,
    output logic                       m_tuser
);

    localparam int AW = ace_pkg::ADDR_W;
    localparam int SW = ace_pkg::SLOT_W;
    localparam int CW = ace_pkg::CNT_W;

    ace_pkg::back_state_t state_reg, state_next;
    ace_pkg::uop_t        cur_reg, cur_next;

    logic [AW-1:0] code_reg, code_next;
    logic [AW-1:0] pool_reg, pool_next;
    logic [CW-1:0] def_cnt_reg, def_cnt_next;
    logic [CW-1:0] pend_cnt_reg, pend_cnt_next;
    logic [CW-1:0] scan_reg, scan_next;
    logic          ovf_reg, ovf_next;
    logic [31:0]   tmp_reg, tmp_next;

    logic [7:0]    def_ids_reg   [ace_pkg::LABEL_SLOTS];
    logic [AW-1:0] def_addrs_reg [ace_pkg::LABEL_SLOTS];
    logic          pend_valid_reg [ace_pkg::LABEL_SLOTS];
    logic [7:0]    pend_ids_reg  [ace_pkg::LABEL_SLOTS];
    logic [AW-1:0] pend_addrs_reg [ace_pkg::LABEL_SLOTS];
    logic [7:0]    pend_ops_reg  [ace_pkg::LABEL_SLOTS];

    logic          hold_v_reg;
    logic [AW-1:0] hold_addr_reg;
    logic [31:0]   hold_data_reg;
    logic          m_valid_reg;
    logic [AW-1:0] m_addr_reg;
    logic [31:0]   m_data_reg;
    logic          m_last_reg;
    logic          m_ovf_reg;

    logic          out_free, can_put;
    logic [SW-1:0] scan_idx;
    logic          def_end, def_hit, slot_end, pend_hit;
    logic [31:0]   back_off, fwd_off, load_off;
    logic          def_room, pend_room;

    logic          put_v;
    logic [AW-1:0] put_addr;
    logic [31:0]   put_data;
    logic          def_we, pend_we, pend_clr, clear_all, flush_move, move;

    assign out_free  = !m_valid_reg || m_tready;
    assign can_put   = !hold_v_reg || out_free;
    assign scan_idx  = scan_reg[SW-1:0];
    assign def_end   = (scan_reg >= def_cnt_reg);
    assign def_hit   = !def_end && (def_ids_reg[scan_idx] == cur_reg.id);
    assign slot_end  = (scan_reg == CW'(ace_pkg::LABEL_SLOTS));
    assign pend_hit  = pend_valid_reg[scan_idx] && (pend_ids_reg[scan_idx] == cur_reg.id);
    assign def_room  = (def_cnt_reg < CW'(ace_pkg::LABEL_SLOTS));
    assign pend_room = (pend_cnt_reg < CW'(ace_pkg::LABEL_SLOTS));
    assign back_off  = 32'(def_addrs_reg[scan_idx]) - 32'(code_reg) - 32'd2;
    assign fwd_off   = 32'(code_reg) - 32'(pend_addrs_reg[scan_idx]) - 32'd2;
    assign load_off  = (32'(pool_reg) - 32'(code_reg) - 32'd2) << 2;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ace_pkg::B_FETCH: begin
                if (q_valid) state_next = ace_pkg::B_EXEC;
            end
            ace_pkg::B_EXEC: begin
                case (cur_reg.kind)
                    ace_pkg::UOP_EMIT: begin
                        if (can_put) begin
                            state_next = cur_reg.fin ? ace_pkg::B_FLUSH : ace_pkg::B_FETCH;
                        end
                    end
                    ace_pkg::UOP_MOVI: begin
                        if (can_put) state_next = ace_pkg::B_MOVI2;
                    end
                    ace_pkg::UOP_BRANCH: state_next = ace_pkg::B_BSCAN;
                    ace_pkg::UOP_LABEL:  state_next = ace_pkg::B_LSCAN;
                    ace_pkg::UOP_INIT:   state_next = ace_pkg::B_FLUSH;
                    default:             state_next = ace_pkg::B_FETCH;
                endcase
            end
            ace_pkg::B_MOVI2: begin
                if (can_put) begin
                    state_next = cur_reg.fin ? ace_pkg::B_FLUSH : ace_pkg::B_FETCH;
                end
            end
            ace_pkg::B_BSCAN: begin
                if (def_end) begin
                    state_next = ace_pkg::B_BEMIT;
                end else if (def_hit) begin
                    state_next = back_off[31] ? ace_pkg::B_BEMIT : ace_pkg::B_FLUSH;
                end
            end
            ace_pkg::B_BEMIT: begin
                if (can_put) state_next = ace_pkg::B_FLUSH;
            end
            ace_pkg::B_LSCAN: begin
                if (slot_end) state_next = ace_pkg::B_FLUSH;
            end
            ace_pkg::B_FLUSH: begin
                if (!hold_v_reg || out_free) state_next = ace_pkg::B_FETCH;
            end
            default: state_next = ace_pkg::B_FETCH;
        endcase
    end

    // datapath controls
    always_comb begin
        cur_next      = cur_reg;
        code_next     = code_reg;
        pool_next     = pool_reg;
        def_cnt_next  = def_cnt_reg;
        pend_cnt_next = pend_cnt_reg;
        scan_next     = scan_reg;
        ovf_next      = ovf_reg;
        tmp_next      = tmp_reg;
        q_pop         = 1'b0;
        put_v         = 1'b0;
        put_addr      = code_reg;
        put_data      = tmp_reg;
        def_we        = 1'b0;
        pend_we       = 1'b0;
        pend_clr      = 1'b0;
        clear_all     = 1'b0;
        flush_move    = 1'b0;
        case (state_reg)
            ace_pkg::B_FETCH: begin
                q_pop    = q_valid;
                cur_next = q_uop;
            end
            ace_pkg::B_EXEC: begin
                case (cur_reg.kind)
                    ace_pkg::UOP_EMIT: begin
                        if (can_put) begin
                            put_v     = 1'b1;
                            put_data  = cur_reg.word;
                            code_next = code_reg + 1'b1;
                        end
                    end
                    ace_pkg::UOP_MOVI: begin
                        if (can_put) begin
                            // constant goes to the pool, the pc-relative load follows
                            put_v     = 1'b1;
                            put_addr  = pool_reg;
                            put_data  = cur_reg.word;
                            tmp_next  = ace_pkg::OP_LDR | {12'b0, 4'd15, cur_reg.rn, 12'b0}
                                        | load_off;
                            pool_next = pool_reg + 1'b1;
                        end
                    end
                    ace_pkg::UOP_BRANCH: scan_next = '0;
                    ace_pkg::UOP_LABEL: begin
                        if (def_room) begin
                            def_we       = 1'b1;
                            def_cnt_next = def_cnt_reg + 1'b1;
                        end else begin
                            ovf_next = 1'b1;
                        end
                        scan_next = '0;
                    end
                    ace_pkg::UOP_INIT: begin
                        clear_all     = 1'b1;
                        code_next     = '0;
                        pool_next     = pool_start;
                        def_cnt_next  = '0;
                        pend_cnt_next = '0;
                        ovf_next      = 1'b0;
                    end
                    default: ;
                endcase
            end
            ace_pkg::B_MOVI2: begin
                if (can_put) begin
                    put_v     = 1'b1;
                    code_next = code_reg + 1'b1;
                end
            end
            ace_pkg::B_BSCAN: begin
                if (def_end) begin
                    // forward branch: record for patching, emit with zero offset
                    if (pend_room) begin
                        pend_we       = 1'b1;
                        pend_cnt_next = pend_cnt_reg + 1'b1;
                    end else begin
                        ovf_next = 1'b1;
                    end
                    tmp_next = {cur_reg.word[7:0], 24'b0};
                end else if (def_hit) begin
                    tmp_next = {cur_reg.word[7:0], back_off[23:0]};
                end else begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            ace_pkg::B_BEMIT: begin
                if (can_put) begin
                    put_v     = 1'b1;
                    code_next = code_reg + 1'b1;
                end
            end
            ace_pkg::B_LSCAN: begin
                if (!slot_end) begin
                    if (pend_hit) begin
                        if (can_put) begin
                            put_v     = 1'b1;
                            put_addr  = pend_addrs_reg[scan_idx];
                            put_data  = {pend_ops_reg[scan_idx], fwd_off[23:0]};
                            pend_clr  = 1'b1;
                            scan_next = scan_reg + 1'b1;
                        end
                    end else begin
                        scan_next = scan_reg + 1'b1;
                    end
                end
            end
            ace_pkg::B_FLUSH: flush_move = hold_v_reg && out_free;
            default: ;
        endcase
    end

    // a held word leaves as not-last when another follows, as last on flush
    assign move = (put_v && hold_v_reg) || flush_move;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0, m_data_reg, m_addr_reg};
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_ovf_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ace_pkg::B_FETCH;
            code_reg     <= '0;
            pool_reg     <= ace_pkg::POOL_START_RESET;
            def_cnt_reg  <= '0;
            pend_cnt_reg <= '0;
            scan_reg     <= '0;
            ovf_reg      <= 1'b0;
            hold_v_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            code_reg     <= code_next;
            pool_reg     <= pool_next;
            def_cnt_reg  <= def_cnt_next;
            pend_cnt_reg <= pend_cnt_next;
            scan_reg     <= scan_next;
            ovf_reg      <= ovf_next;
            if (put_v) begin
                hold_v_reg <= 1'b1;
            end else if (flush_move) begin
                hold_v_reg <= 1'b0;
            end
            if (move) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < ace_pkg::LABEL_SLOTS; i++) begin
            if (!aresetn || clear_all) begin
                pend_valid_reg[i] <= 1'b0;
            end else if (pend_we && pend_cnt_reg[SW-1:0] == SW'(i)) begin
                pend_valid_reg[i] <= 1'b1;
            end else if (pend_clr && scan_idx == SW'(i)) begin
                pend_valid_reg[i] <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
        tmp_reg <= tmp_next;
        if (def_we) begin
            def_ids_reg[def_cnt_reg[SW-1:0]]   <= cur_reg.id;
            def_addrs_reg[def_cnt_reg[SW-1:0]] <= code_reg;
        end
        if (pend_we) begin
            pend_ids_reg[pend_cnt_reg[SW-1:0]]   <= cur_reg.id;
            pend_addrs_reg[pend_cnt_reg[SW-1:0]] <= code_reg;
            pend_ops_reg[pend_cnt_reg[SW-1:0]]   <= cur_reg.word[7:0];
        end
        if (put_v) begin
            hold_addr_reg <= put_addr;
            hold_data_reg <= put_data;
        end
        if (move) begin
            m_addr_reg <= hold_addr_reg;
            m_data_reg <= hold_data_reg;
            m_last_reg <= flush_move;
            m_ovf_reg  <= ovf_reg;
        end
    end

endmodule

`default_nettype wire

/* sv/arm_code_emitter_with_backpatch.sv */
// top level of the arm code emitter with branch backpatching
// uses ace_pkg, ace_front, ace_queue, ace_back
//
// usage:
//   s_ channel: one emit command per word (cmd, registers, immediate, label id).
//   m_ channel: one code-buffer write per word (word index and data); tlast marks
//   the final write of a command, tuser carries the sticky table overflow flag.
//   cfg port: cfg_we writes pool_start (index 0) or the divide routine address
//   (index 1); write only while the block is idle.
// timing:
//   the front end expands a command into micro-ops, one per cycle while the
//   four-entry queue is not full; the back end fetches each micro-op and then
//   executes it, a pool load takes an extra step, and each command ends with a
//   flush step. a divide into r0 skips the final move back into d.
//   branches scan the defined-label table one entry per cycle (up to 32),
//   label definitions scan all 32 pending slots.
//   the front end takes the next command as soon as it has queued the last step.
// reset: indexes, counts, pending valid bits and the overflow flag clear,
//   the pool index loads 128, config returns to defaults.
// stall: a held word plus the output register decouple the engine from m_tready;
//   the engine stalls only when both are full.
`default_nettype none

module arm_code_emitter_with_backpatch (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // cmd[4:0] dst_reg[8:5] src_reg[12:9] immediate[44:13] label_id[52:45]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // write_addr[11:0] write_data[43:12]
    output logic        m_tlast,   // last
    output logic        m_tuser,   // table_overflow
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_wdata
);

    logic [ace_pkg::ADDR_W-1:0] pool_start_reg;
    logic [31:0]                div_addr_reg;

    logic          q_push, q_full, q_pop, q_valid;
    ace_pkg::uop_t push_uop, head_uop;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_start_reg <= ace_pkg::POOL_START_RESET;
            div_addr_reg   <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                ace_pkg::CFG_POOL_START: pool_start_reg <= cfg_wdata[ace_pkg::ADDR_W-1:0];
                ace_pkg::CFG_DIV_ADDR:   div_addr_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // command decode and expansion
    ace_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .div_addr (div_addr_reg),
        .q_full   (q_full),
        .push     (q_push),
        .push_uop (push_uop)
    );

    // micro-op queue
    ace_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_uop (push_uop),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .head_uop (head_uop)
    );

    // execution, label tables and result words
    ace_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .pool_start (pool_start_reg),
        .q_valid    (q_valid),
        .q_uop      (head_uop),
        .q_pop      (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

    // front end holds off new commands while expanding one
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("command accepted while expansion in progress");

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_full)
        else $error("micro-op pushed into full queue");

    a_pop_only_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("micro-op popped from empty queue");

endmodule

`default_nettype wire

/* sim/arm_code_emitter_with_backpatch_test.sv */
// self-checking testbench of the arm code emitter with branch backpatching
// code-buffer writes are predicted per command and checked in order
// depends on ace_pkg and arm_code_emitter_with_backpatch
`timescale 1ns / 1ps

module arm_code_emitter_with_backpatch_test;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 400;  // covers a full queue of label and branch scans

    typedef struct {
        logic [11:0] addr;
        logic [31:0] data;
        logic        last;
        logic        ovf;
    } code_write_t;

    // predicts the code-buffer writes of each accepted command
    class emit_scoreboard;
        code_write_t expected_writes[$];
        code_write_t cmd_writes[$];
        int          errors;

        logic [11:0] pool_start_reg;
        logic [31:0] div_addr_reg;

        logic [11:0] code_pos;
        logic [11:0] pool_idx;
        int          def_count;
        logic [7:0]  def_ids[ace_pkg::LABEL_SLOTS];
        logic [11:0] def_addrs[ace_pkg::LABEL_SLOTS];
        int          pend_count;
        bit          pend_valid[ace_pkg::LABEL_SLOTS];
        logic [7:0]  pend_ids[ace_pkg::LABEL_SLOTS];
        logic [11:0] pend_addrs[ace_pkg::LABEL_SLOTS];
        logic [7:0]  pend_tops[ace_pkg::LABEL_SLOTS];
        bit          ovf_flag;

        function new();
            errors = 0;
            pool_start_reg = 12'd128;
            div_addr_reg = 32'd0;
            clear_tables();
        endfunction

        function void clear_tables();
            code_pos = '0;
            pool_idx = pool_start_reg;
            def_count = 0;
            pend_count = 0;
            ovf_flag = 0;
            foreach (pend_valid[i]) pend_valid[i] = 0;
        endfunction

        function void write_reg(logic idx, logic [31:0] val);
            if (idx == ace_pkg::CFG_POOL_START) pool_start_reg = val[11:0];
            else div_addr_reg = val;
        endfunction

        function void put(logic [11:0] addr, logic [31:0] data);
            code_write_t w;
            w.addr = addr;
            w.data = data;
            w.last = 0;
            w.ovf = 0;
            cmd_writes.push_back(w);
        endfunction

        function void emit(logic [31:0] word);
            put(code_pos, word);
            code_pos = code_pos + 12'd1;
        endfunction

        function void emit_mov(logic [3:0] d, logic [3:0] s);
            emit(ace_pkg::OP_MOV | {16'b0, d, 8'b0, s});
        endfunction

        // pc-relative load of a pool constant
        function void emit_pool_load(logic [3:0] rd, logic [31:0] imm);
            logic [31:0] op;
            op = ace_pkg::OP_LDR | (32'd15 << 16) | (32'(rd) << 12);
            op |= (32'(pool_idx) - 32'(code_pos) - 32'd2) * 32'd4;
            put(pool_idx, imm);
            pool_idx = pool_idx + 12'd1;
            emit(op);
        endfunction

        function void emit_call(logic [31:0] target);
            emit(ace_pkg::OP_PUSH);
            emit_mov(4'd14, 4'd15);
            emit_pool_load(4'd15, target);
            emit(ace_pkg::OP_POP);
        endfunction

        function void branch(logic [7:0] top, logic [7:0] id);
            logic [31:0] op;
            int          off;
            op = {top, 24'b0};
            for (int i = 0; i < def_count; i++) begin
                if (def_ids[i] == id) begin
                    off = int'(def_addrs[i]) - int'(code_pos) - 2;
                    if (off < 0) emit(op | (32'(off) & 32'h00ffffff));
                    return;
                end
            end
            if (pend_count < ace_pkg::LABEL_SLOTS) begin
                pend_valid[pend_count] = 1;
                pend_ids[pend_count] = id;
                pend_addrs[pend_count] = code_pos;
                pend_tops[pend_count] = top;
                pend_count++;
            end else begin
                ovf_flag = 1;
            end
            emit(op);
        endfunction

        function void define_label(logic [7:0] id);
            logic [31:0] off;
            if (def_count < ace_pkg::LABEL_SLOTS) begin
                def_ids[def_count] = id;
                def_addrs[def_count] = code_pos;
                def_count++;
            end else begin
                ovf_flag = 1;
            end
            for (int i = 0; i < ace_pkg::LABEL_SLOTS; i++) begin
                if (pend_valid[i] && pend_ids[i] == id) begin
                    off = (32'(code_pos) - 32'(pend_addrs[i]) - 32'd2) & 32'h00ffffff;
                    put(pend_addrs[i], {pend_tops[i], 24'b0} | off);
                    pend_valid[i] = 0;
                end
            end
        endfunction

        function void note_command(logic [4:0] cmd, logic [3:0] d, logic [3:0] s,
                                   logic [31:0] imm, logic [7:0] id);
            cmd_writes.delete();
            case (cmd)
                ace_pkg::CMD_INIT:  clear_tables();
                ace_pkg::CMD_MOVI:  emit_pool_load(d, imm);
                ace_pkg::CMD_MOVR:  emit_mov(d, s);
                ace_pkg::CMD_MOVMI: emit(ace_pkg::OP_MOVMI | {16'b0, d, 8'b0, s});
                ace_pkg::CMD_MOVNE: emit(ace_pkg::OP_MOVNE | {16'b0, d, 8'b0, s});
                ace_pkg::CMD_LDR:
                    emit(ace_pkg::OP_LDR | (32'(d) << 16) | (32'(d) << 12));
                ace_pkg::CMD_LDRB:
                    emit(ace_pkg::OP_LDR | ace_pkg::BYTE_BIT | (32'd3 << 16) | (32'(d) << 12));
                ace_pkg::CMD_STRB:
                    emit(ace_pkg::OP_STR | ace_pkg::BYTE_BIT | (32'd3 << 16) | (32'(d) << 12));
                ace_pkg::CMD_STRW:
                    emit(ace_pkg::OP_STR | (32'(d) << 16) | (32'd3 << 12));
                ace_pkg::CMD_ADDR:
                    emit(ace_pkg::OP_ADDS | 32'(s) | (32'(d) << 12) | (32'(d) << 16));
                ace_pkg::CMD_ADDI: begin
                    emit_pool_load(4'd9, imm);
                    emit(ace_pkg::OP_ADDS | 32'd9 | (32'(d) << 12) | (32'(d) << 16));
                end
                ace_pkg::CMD_SUBR:
                    emit(ace_pkg::OP_SUBS | 32'(s) | (32'(d) << 12) | (32'(d) << 16));
                ace_pkg::CMD_MULR:
                    emit(ace_pkg::OP_MULS | (32'(s) << 8) | 32'(d) | (32'(d) << 16));
                ace_pkg::CMD_CALL:  emit_call(imm);
                ace_pkg::CMD_DIVR: begin
                    emit_mov(4'd0, d);
                    emit_mov(4'd1, s);
                    emit_call(div_addr_reg);
                    if (d != 0) emit_mov(d, 4'd0);
                end
                ace_pkg::CMD_CMPR:  emit(ace_pkg::OP_CMP | 32'(s) | (32'(d) << 16));
                ace_pkg::CMD_CMPI:
                    emit(ace_pkg::OP_CMPI | (imm & 32'h0000ffff) | (32'(s) << 16));
                ace_pkg::CMD_BEQ:   branch(ace_pkg::BR_EQ, id);
                ace_pkg::CMD_BNE:   branch(ace_pkg::BR_NE, id);
                ace_pkg::CMD_BMI:   branch(ace_pkg::BR_MI, id);
                ace_pkg::CMD_B:     branch(ace_pkg::BR_AL, id);
                ace_pkg::CMD_LABEL: define_label(id);
                ace_pkg::CMD_RET:   emit_mov(4'd15, 4'd14);
                default: ;
            endcase
            foreach (cmd_writes[k]) begin
                cmd_writes[k].last = (k == cmd_writes.size() - 1);
                cmd_writes[k].ovf = ovf_flag;
                expected_writes.push_back(cmd_writes[k]);
            end
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            errors++;
        endtask

        task check_write(logic [11:0] addr, logic [31:0] data, logic last, logic ovf);
            code_write_t w;
            if (expected_writes.size() == 0) begin
                report($sformatf("unexpected word addr %h data %h", addr, data));
                return;
            end
            w = expected_writes.pop_front();
            if (addr !== w.addr)
                report($sformatf("write_addr %h, predicted %h", addr, w.addr));
            if (data !== w.data)
                report($sformatf("write_data %h, predicted %h (addr %h)", data, w.data, w.addr));
            if (last !== w.last)
                report($sformatf("last %b, predicted %b (addr %h)", last, w.last, w.addr));
            if (ovf !== w.ovf)
                report($sformatf("table_overflow %b, predicted %b", ovf, w.ovf));
        endtask

        task check_drained();
            if (expected_writes.size() != 0)
                report($sformatf("%0d predicted words never arrived", expected_writes.size()));
        endtask
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;   // cmd[4:0] dst_reg[8:5] src_reg[12:9] immediate[44:13] label_id[52:45]
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [47:0] m_tdata;        // write_addr[11:0] write_data[43:12]
    logic        m_tlast;        // last
    logic        m_tuser;        // table_overflow
    logic        cfg_we = 0;
    logic        cfg_index = 0;
    logic [31:0] cfg_wdata = '0;

    emit_scoreboard sb = new();
    bit idle_en = 1;        // random gaps on both sides
    int stall_left = 0;
    int quiet_cycles = 0;

    arm_code_emitter_with_backpatch u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // result side: check every accepted word, random backpressure, watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                sb.check_write(m_tdata[11:0], m_tdata[43:12], m_tlast, m_tuser);
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 0;
            end else if (idle_en && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 7) - 1;
                m_tready <= 0;
            end else begin
                m_tready <= 1;
            end
        end
    end

    // offer one command word and hold it until accepted
    task send_cmd(logic [4:0] cmd, logic [3:0] d, logic [3:0] s,
                  logic [31:0] imm, logic [7:0] id);
        if (idle_en && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= {3'b0, id, imm, s, d, cmd};
        do @(posedge aclk); while (!s_tready);
        sb.note_command(cmd, d, s, imm, id);
    endtask

    task send_random_cmd();
        int          pick;
        logic [4:0]  cmd;
        logic [7:0]  id;
        pick = $urandom_range(0, 99);
        // most label traffic uses a few ids so branches meet their labels
        id = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 11));
        if (pick < 30) cmd = 5'($urandom_range(ace_pkg::CMD_BEQ, ace_pkg::CMD_B));
        else if (pick < 45) cmd = ace_pkg::CMD_LABEL;
        else if (pick < 48) cmd = ace_pkg::CMD_INIT;
        else if (pick < 50) cmd = 5'($urandom_range(23, 31));
        else if (pick < 53) cmd = ace_pkg::CMD_RET;
        else cmd = 5'($urandom_range(ace_pkg::CMD_MOVI, ace_pkg::CMD_CMPI));
        send_cmd(cmd, 4'($urandom), 4'($urandom), $urandom, id);
    endtask

    // wait until every predicted word is out and any trailing scan has finished
    task wait_idle();
        s_tvalid <= 0;
        while (sb.expected_writes.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task cfg_write(logic idx, logic [31:0] val);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 0;
        sb.write_reg(idx, val);
        @(posedge aclk);
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // a few words with reset settings first
        send_cmd(ace_pkg::CMD_MOVI, 4'd0, 4'd0, 32'h0, 8'd0);
        send_cmd(ace_pkg::CMD_DIVR, 4'd3, 4'd4, 32'h0, 8'd0);
        wait_idle();

        // phase one: lowest pool start, all-ones divide address, directed commands
        cfg_write(ace_pkg::CFG_POOL_START, 32'd0);
        cfg_write(ace_pkg::CFG_DIV_ADDR, 32'hffffffff);
        send_cmd(ace_pkg::CMD_INIT, 4'd0, 4'd0, 32'h0, 8'd0);
        send_cmd(ace_pkg::CMD_MOVI, 4'd15, 4'd0, 32'hffffffff, 8'd0);
        send_cmd(ace_pkg::CMD_MOVR, 4'd15, 4'd15, 32'h0, 8'd0);
        for (int c = ace_pkg::CMD_MOVMI; c <= ace_pkg::CMD_CALL; c++)
            send_cmd(5'(c), 4'($urandom), 4'($urandom), $urandom, 8'd0);
        // divide into r0 skips the final move
        send_cmd(ace_pkg::CMD_DIVR, 4'd0, 4'd15, 32'h0, 8'd0);
        send_cmd(ace_pkg::CMD_CMPR, 4'd15, 4'd0, 32'h0, 8'd0);
        send_cmd(ace_pkg::CMD_CMPI, 4'd0, 4'd15, 32'hffffffff, 8'd0);
        send_cmd(ace_pkg::CMD_BEQ, 4'd0, 4'd0, 32'h0, 8'd255);   // forward, patched below
        send_cmd(ace_pkg::CMD_BNE, 4'd0, 4'd0, 32'h0, 8'd255);
        send_cmd(ace_pkg::CMD_LABEL, 4'd0, 4'd0, 32'h0, 8'd255);
        send_cmd(ace_pkg::CMD_LABEL, 4'd0, 4'd0, 32'h0, 8'd0);
        send_cmd(ace_pkg::CMD_BMI, 4'd0, 4'd0, 32'h0, 8'd0);     // backward
        send_cmd(ace_pkg::CMD_B, 4'd0, 4'd0, 32'h0, 8'd255);
        send_cmd(ace_pkg::CMD_LABEL, 4'd0, 4'd0, 32'h0, 8'd77);  // nothing waits on it
        send_cmd(ace_pkg::CMD_RET, 4'd0, 4'd0, 32'h0, 8'd0);
        send_cmd(5'd23, 4'd0, 4'd0, 32'h0, 8'd0);       // unused codes
        send_cmd(5'd31, 4'd15, 4'd15, 32'hffffffff, 8'd255);
        wait_idle();

        // phase two: top pool start, both tables overflow, then random traffic
        cfg_write(ace_pkg::CFG_POOL_START, 32'd4095);
        cfg_write(ace_pkg::CFG_DIV_ADDR, $urandom);
        send_cmd(ace_pkg::CMD_INIT, 4'd0, 4'd0, 32'h0, 8'd0);
        for (int i = 0; i < 36; i++)
            send_cmd(5'($urandom_range(ace_pkg::CMD_BEQ, ace_pkg::CMD_B)), 4'd0, 4'd0,
                     32'h0, 8'(100 + i));
        for (int i = 0; i < 36; i++)
            send_cmd(ace_pkg::CMD_LABEL, 4'd0, 4'd0, 32'h0, 8'(100 + i));
        for (int i = 0; i < 100; i++) send_random_cmd();
        wait_idle();

        // phase three: random settings, last stretch without gaps
        cfg_write(ace_pkg::CFG_POOL_START, 32'($urandom_range(1, 4094)));
        cfg_write(ace_pkg::CFG_DIV_ADDR, $urandom);
        send_cmd(ace_pkg::CMD_INIT, 4'd0, 4'd0, 32'h0, 8'd0);
        for (int i = 0; i < 300; i++) begin
            if (i == 200) idle_en = 0;
            send_random_cmd();
        end
        wait_idle();

        sb.check_drained();
        if (sb.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
